/* rtl/iprl_pkg.sv */
package iprl_pkg;

	// store sizes
	localparam int unsigned FIRST_INDEX_DEPTH = 256;
	localparam int unsigned MAIN_INDEX_DEPTH  = 4096;
	localparam int unsigned BLOCK_DEPTH       = 65536;

	// field widths
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned LOW_W   = 24;
	localparam int unsigned ID_W    = 24;
	localparam int unsigned SLOT_W  = 16;
	localparam int unsigned RNG_W   = 16;
	localparam int unsigned CNT_W   = 17;
	localparam int unsigned FIL_W   = 8;
	localparam int unsigned MIL_W   = 13;
	localparam int unsigned CIDX_W  = 8;
	localparam int unsigned CDATA_W = 32;
	localparam int unsigned PART_W  = 32;
	localparam int unsigned BND_W   = PART_W + 1 + RNG_W;

	// reserved first bytes and search span
	localparam logic [7:0] PRIVATE_NET  = 8'd10;
	localparam logic [7:0] LOOPBACK_NET = 8'd127;
	localparam int unsigned SCAN_SPAN   = 8;

	// request kinds
	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_WR_FIRST = 2'd1,
		REQ_WR_MAIN = 2'd2,
		REQ_WR_BLOCK = 2'd3
	} req_t;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_RANGE_SIZE      = 8'd0;
	localparam logic [CIDX_W-1:0] REG_DB_ITEM_COUNT   = 8'd1;
	localparam logic [CIDX_W-1:0] REG_FIRST_INDEX_LEN = 8'd2;
	localparam logic [CIDX_W-1:0] REG_MAIN_INDEX_LEN  = 8'd3;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] num;
		logic [RNG_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quot;
	} div_rsp_t;

	// sequencer states
	typedef enum logic [19:0] {
		ST_IDLE = 20'h00001,
		ST_FI0  = 20'h00002,
		ST_FI1  = 20'h00004,
		ST_FI2  = 20'h00008,
		ST_DLO  = 20'h00010,
		ST_DHI  = 20'h00020,
		ST_PB   = 20'h00040,
		ST_PBW  = 20'h00080,
		ST_PS   = 20'h00100,
		ST_PSW  = 20'h00200,
		ST_MUL0 = 20'h00400,
		ST_MUL1 = 20'h00800,
		ST_CLP1 = 20'h01000,
		ST_CLP2 = 20'h02000,
		ST_BB   = 20'h04000,
		ST_BBW  = 20'h08000,
		ST_BS   = 20'h10000,
		ST_BSW  = 20'h20000,
		ST_RID  = 20'h40000,
		ST_RIDW = 20'h80000
	} state_t;

endpackage

/* rtl/ip_range_location_lookup.sv */
// channel | direction | signals                       | contents
// s       | in        | s_tvalid s_tready s_tdata/tuser | requests: lookups and table writes
// m       | out       | m_tvalid m_tready m_tdata/tuser | lookup results
// cfg     | in        | cfg_valid cfg_ready cfg_index/data | register writes
// table writes give no result; a refused lookup gives its result in the cycle
// after acceptance. a full lookup runs the first-index reads, two passes through
// the shared serial divider, then the index and block reads in the searches and
// scans, then the final block read for the id.
// s_tready is low while a lookup is in work or a result waits on m.
// asynchronous reset resets the sequencer and configuration registers; stores are not cleared.
module ip_range_location_lookup #(
	parameter int unsigned MAIN_INDEX_DEPTH = iprl_pkg::MAIN_INDEX_DEPTH,
	parameter int unsigned BLOCK_DEPTH      = iprl_pkg::BLOCK_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// table_slot[15:0], index_word[47:16], block_low_addr[71:48],
	// block_id[95:72], lookup_addr[127:96]
	input  logic [127:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// location_id[23:0]
	output logic [23:0]  m_tdata,
	// refused[0]
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int unsigned FAW = $clog2(iprl_pkg::FIRST_INDEX_DEPTH);
	localparam int unsigned MAW = $clog2(MAIN_INDEX_DEPTH);
	localparam int unsigned BAW = $clog2(BLOCK_DEPTH);
	localparam int unsigned PW  = iprl_pkg::PART_W;
	localparam int unsigned BW  = iprl_pkg::BND_W;
	localparam int unsigned LW  = iprl_pkg::LOW_W;
	localparam int unsigned IW  = iprl_pkg::ID_W;

	iprl_pkg::state_t state_q;

	// configuration registers
	logic [iprl_pkg::RNG_W-1:0] range_size_q;
	logic [iprl_pkg::CNT_W-1:0] db_item_count_q;
	logic [iprl_pkg::FIL_W-1:0] first_index_len_q;
	logic [iprl_pkg::MIL_W-1:0] main_index_len_q;
	logic [iprl_pkg::RNG_W-1:0] rng;

	// lookup registers
	logic [31:0]   addr_q;
	logic [31:0]   lo_b_q, hi_b_q;
	logic [PW-1:0] plo_q, phi_q, pmid_q, part_q;
	logic [BW-1:0] bmin_q, bmax_q, bmid_q;
	logic [BAW-1:0] idx_q;
	logic          out_valid_q;
	logic [IW-1:0] out_id_q;
	logic          out_ref_q;

	// request fields
	logic [1:0]  f_req;
	logic [15:0] f_slot;
	logic [31:0] f_word;
	logic [LW-1:0] f_low;
	logic [IW-1:0] f_id;
	logic [31:0] f_addr;
	logic [7:0]  f_fb;
	logic        accept;
	logic        refuse;

	assign f_req  = s_tuser;
	assign f_slot = s_tdata[15:0];
	assign f_word = s_tdata[47:16];
	assign f_low  = s_tdata[71:48];
	assign f_id   = s_tdata[95:72];
	assign f_addr = s_tdata[127:96];
	assign f_fb   = f_addr[31:24];

	assign s_tready = (state_q == iprl_pkg::ST_IDLE) && !out_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign refuse   = (f_fb == 8'd0) || (f_fb == iprl_pkg::PRIVATE_NET) ||
	                  (f_fb == iprl_pkg::LOOPBACK_NET) || (f_fb > first_index_len_q);

	assign rng = (range_size_q == '0) ? iprl_pkg::RNG_W'(1) : range_size_q;

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_size_q      <= iprl_pkg::RNG_W'(1);
			db_item_count_q   <= '0;
			first_index_len_q <= '0;
			main_index_len_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				iprl_pkg::REG_RANGE_SIZE:      range_size_q <= cfg_data[iprl_pkg::RNG_W-1:0];
				iprl_pkg::REG_DB_ITEM_COUNT:   db_item_count_q <= cfg_data[iprl_pkg::CNT_W-1:0];
				iprl_pkg::REG_FIRST_INDEX_LEN: first_index_len_q <= cfg_data[iprl_pkg::FIL_W-1:0];
				iprl_pkg::REG_MAIN_INDEX_LEN:  main_index_len_q <= cfg_data[iprl_pkg::MIL_W-1:0];
				default: ;
			endcase
		end
	end

	// table stores
	logic           fi_we, mi_we, bl_we;
	logic [FAW-1:0] fi_raddr;
	logic [MAW-1:0] mi_raddr;
	logic [BAW-1:0] bl_raddr;
	logic [31:0]    fi_rdata, mi_rdata;
	logic [LW+IW-1:0] bl_rdata;

	assign fi_we = accept && (f_req == iprl_pkg::REQ_WR_FIRST) &&
	               (32'(f_slot) < 32'(iprl_pkg::FIRST_INDEX_DEPTH));
	assign mi_we = accept && (f_req == iprl_pkg::REQ_WR_MAIN) &&
	               (32'(f_slot) < 32'(MAIN_INDEX_DEPTH));
	assign bl_we = accept && (f_req == iprl_pkg::REQ_WR_BLOCK) &&
	               (32'(f_slot) < 32'(BLOCK_DEPTH));

	iprl_ram #(.AW(FAW), .DW(32)) u_first (
		.clk(clk), .we(fi_we), .waddr(FAW'(f_slot)), .wdata(f_word),
		.raddr(fi_raddr), .rdata(fi_rdata)
	);

	iprl_ram #(.AW(MAW), .DW(32)) u_main (
		.clk(clk), .we(mi_we), .waddr(MAW'(f_slot)), .wdata(f_word),
		.raddr(mi_raddr), .rdata(mi_rdata)
	);

	iprl_ram #(.AW(BAW), .DW(LW + IW)) u_block (
		.clk(clk), .we(bl_we), .waddr(BAW'(f_slot)), .wdata({f_id, f_low}),
		.raddr(bl_raddr), .rdata(bl_rdata)
	);

	// midpoints of the two search windows
	logic [PW:0]   pmid_w;
	logic [BW:0]   bmid_w;
	logic [PW-1:0] pdiff;
	logic [BW-1:0] bdiff;
	logic [LW-1:0] key;

	assign pmid_w = ({1'b0, plo_q} + {1'b0, phi_q}) >> 1;
	assign bmid_w = ({1'b0, bmin_q} + {1'b0, bmax_q}) >> 1;
	assign pdiff  = phi_q - plo_q;
	assign bdiff  = bmax_q - bmin_q;
	assign key    = addr_q[LW-1:0];

	// read address selection
	always_comb begin
		fi_raddr = (state_q == iprl_pkg::ST_FI0) ? FAW'(addr_q[31:24] - 8'd1)
		                                         : FAW'(addr_q[31:24]);
		mi_raddr = (state_q == iprl_pkg::ST_PB) ? pmid_w[MAW-1:0] : plo_q[MAW-1:0];
		case (state_q)
			iprl_pkg::ST_BB: bl_raddr = bmid_w[BAW-1:0];
			iprl_pkg::ST_BS: bl_raddr = bmin_q[BAW-1:0];
			default:         bl_raddr = idx_q;
		endcase
	end

	// shared divider: lower bound first, then upper bound
	iprl_pkg::div_req_t div_req;
	iprl_pkg::div_rsp_t div_rsp;

	assign div_req.start = (state_q == iprl_pkg::ST_FI2) ||
	                       ((state_q == iprl_pkg::ST_DLO) && div_rsp.done);
	assign div_req.num   = (state_q == iprl_pkg::ST_FI2) ? lo_b_q : hi_b_q;
	assign div_req.den   = rng;

	iprl_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	// bound multiplier
	logic [PW:0]   mul_a;
	logic [BW-1:0] prod;
	logic [PW-1:0] hi_m1;

	assign mul_a = (state_q == iprl_pkg::ST_MUL0) ? {1'b0, part_q}
	                                              : ({1'b0, part_q} + 1'b1);
	assign prod  = BW'(mul_a) * BW'(rng);
	assign hi_m1 = (div_rsp.quot == '0) ? '0 : div_rsp.quot - 1'b1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iprl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				iprl_pkg::ST_IDLE: begin
					if (accept && (f_req == iprl_pkg::REQ_LOOKUP)) begin
						if (refuse) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= iprl_pkg::ST_FI0;
						end
					end
				end
				iprl_pkg::ST_FI0: state_q <= iprl_pkg::ST_FI1;
				iprl_pkg::ST_FI1: state_q <= iprl_pkg::ST_FI2;
				iprl_pkg::ST_FI2: state_q <= iprl_pkg::ST_DLO;
				iprl_pkg::ST_DLO: if (div_rsp.done) state_q <= iprl_pkg::ST_DHI;
				iprl_pkg::ST_DHI: if (div_rsp.done) state_q <= iprl_pkg::ST_PB;
				iprl_pkg::ST_PB: begin
					state_q <= (pdiff > PW'(iprl_pkg::SCAN_SPAN)) ? iprl_pkg::ST_PBW
					                                             : iprl_pkg::ST_PS;
				end
				iprl_pkg::ST_PBW: state_q <= iprl_pkg::ST_PB;
				iprl_pkg::ST_PS:  state_q <= iprl_pkg::ST_PSW;
				iprl_pkg::ST_PSW: begin
					state_q <= ((addr_q > mi_rdata) && (plo_q < phi_q)) ? iprl_pkg::ST_PS
					                                                   : iprl_pkg::ST_MUL0;
				end
				iprl_pkg::ST_MUL0: state_q <= iprl_pkg::ST_MUL1;
				iprl_pkg::ST_MUL1: state_q <= iprl_pkg::ST_CLP1;
				iprl_pkg::ST_CLP1: state_q <= iprl_pkg::ST_CLP2;
				iprl_pkg::ST_CLP2: begin
					state_q <= (bmax_q <= bmin_q) ? iprl_pkg::ST_RID : iprl_pkg::ST_BB;
				end
				iprl_pkg::ST_BB: begin
					state_q <= (bdiff > BW'(iprl_pkg::SCAN_SPAN)) ? iprl_pkg::ST_BBW
					                                             : iprl_pkg::ST_BS;
				end
				iprl_pkg::ST_BBW: state_q <= iprl_pkg::ST_BB;
				iprl_pkg::ST_BS:  state_q <= iprl_pkg::ST_BSW;
				iprl_pkg::ST_BSW: begin
					state_q <= ((key >= bl_rdata[LW-1:0]) && (bmin_q < bmax_q))
					           ? iprl_pkg::ST_BS : iprl_pkg::ST_RID;
				end
				iprl_pkg::ST_RID: state_q <= iprl_pkg::ST_RIDW;
				iprl_pkg::ST_RIDW: begin
					out_valid_q <= 1'b1;
					state_q     <= iprl_pkg::ST_IDLE;
				end
				default: state_q <= iprl_pkg::ST_IDLE;
			endcase
		end
	end

	// lookup datapath
	always_ff @(posedge clk) begin
		case (state_q)
			iprl_pkg::ST_IDLE: begin
				if (accept) begin
					addr_q    <= f_addr;
					out_id_q  <= '0;
					out_ref_q <= 1'b1;
				end
			end
			iprl_pkg::ST_FI1: lo_b_q <= fi_rdata;
			iprl_pkg::ST_FI2: hi_b_q <= fi_rdata;
			iprl_pkg::ST_DLO: if (div_rsp.done) plo_q <= div_rsp.quot;
			iprl_pkg::ST_DHI: begin
				if (div_rsp.done) begin
					phi_q <= (hi_m1 < plo_q) ? plo_q : hi_m1;
				end
			end
			iprl_pkg::ST_PB: pmid_q <= pmid_w[PW-1:0];
			iprl_pkg::ST_PBW: begin
				if (addr_q > mi_rdata) begin
					plo_q <= pmid_q;
				end else begin
					phi_q <= pmid_q;
				end
			end
			iprl_pkg::ST_PSW: begin
				if ((addr_q > mi_rdata) && (plo_q < phi_q)) begin
					plo_q <= plo_q + 1'b1;
				end else begin
					part_q <= plo_q;
				end
			end
			iprl_pkg::ST_MUL0: bmin_q <= prod;
			iprl_pkg::ST_MUL1: begin
				bmax_q <= (part_q > PW'(main_index_len_q)) ? BW'(db_item_count_q) : prod;
			end
			iprl_pkg::ST_CLP1: begin
				if (bmin_q < BW'(lo_b_q)) bmin_q <= BW'(lo_b_q);
				if (bmax_q > BW'(hi_b_q)) bmax_q <= BW'(hi_b_q);
			end
			iprl_pkg::ST_CLP2: idx_q <= bmin_q[BAW-1:0];
			iprl_pkg::ST_BB: bmid_q <= bmid_w[BW-1:0];
			iprl_pkg::ST_BBW: begin
				if (key > bl_rdata[LW-1:0]) begin
					bmin_q <= bmid_q;
				end else begin
					bmax_q <= bmid_q;
				end
			end
			iprl_pkg::ST_BSW: begin
				if ((key >= bl_rdata[LW-1:0]) && (bmin_q < bmax_q)) begin
					bmin_q <= bmin_q + 1'b1;
				end else begin
					idx_q <= bmin_q[BAW-1:0] - 1'b1;
				end
			end
			iprl_pkg::ST_RIDW: begin
				out_id_q  <= bl_rdata[LW+IW-1:LW];
				out_ref_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// result port
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_id_q;
	assign m_tuser[0] = out_ref_q;

endmodule

/* rtl/iprl_ram.sv */
module iprl_ram #(
	parameter int unsigned AW = 8,
	parameter int unsigned DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/iprl_div.sv */
module iprl_div (
	input  logic               clk,
	input  logic               arst_n,
	input  iprl_pkg::div_req_t req,
	output iprl_pkg::div_rsp_t rsp
);

	localparam int unsigned NW = iprl_pkg::WORD_W;
	localparam int unsigned DW = iprl_pkg::RNG_W;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] quot_q;
	logic [DW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          fits;

	// restoring division, one quotient bit a cycle
	assign rem_sh = {rem_q[DW-1:0], quot_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? (rem_sh - {1'b0, req.den}) : rem_sh;
			quot_q <= {quot_q[NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

/* rtl/iprl_chk.sv */
module iprl_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [127:0] s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [23:0]  m_tdata,
	input logic [0:0]   m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// refused results carry a zero id
	a_ref_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 24'd0)
		else $error("refused result with nonzero id");

	// no new transaction while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken while result pending");

	// a lookup of first byte zero is refused on the next cycle
	a_fast_ref: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == iprl_pkg::REQ_LOOKUP && s_tdata[127:120] == 8'd0
		|=> m_tvalid && m_tuser[0])
		else $error("reserved first byte not refused");

endmodule

bind ip_range_location_lookup iprl_chk u_iprl_chk (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
